// ===== sv/rrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rrf_pkg: shared types and constants for the rangefinder response framer
// Beat payloads, register indexes, microcode format and the CRC byte step.
// ----------------------------------------------------------------------------
package rrf_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int STEP_W      = 5;

  localparam logic [7:0]  FUNC_CODE = 8'h04;
  localparam logic [7:0]  LEN_BYTE  = 8'd25;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  localparam logic [7:0]  RST_ADDR = 8'd1;
  localparam logic [15:0] RST_TEMP = 16'd1245;
  localparam logic [15:0] RST_DETS = 16'd1;
  localparam logic [15:0] RST_AMPL = 16'd37;

  localparam logic [7:0] REG_ADDR = 8'd0;
  localparam logic [7:0] REG_TEMP = 8'd1;
  localparam logic [7:0] REG_DETS = 8'd2;
  localparam logic [7:0] REG_AMPL = 8'd3;

  typedef struct packed {
    logic [15:0] altitude_cm;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } out_item_t;

  typedef enum logic [3:0] {
    SRC_ADDR, SRC_FUNC, SRC_LEN,
    SRC_T2, SRC_T3, SRC_T0, SRC_T1,
    SRC_TEMP_LO, SRC_TEMP_HI, SRC_DETS_HI, SRC_DETS_LO,
    SRC_DIST_HI, SRC_DIST_LO, SRC_AMPL_HI, SRC_AMPL_LO,
    SRC_CRC_LO
  } src_t;

  // One control word per step. crc_en folds the byte into the CRC;
  // last ends the program and jumps back to idle.
  typedef struct packed {
    src_t src;
    logic hi;
    logic crc_en;
    logic last;
  } ctrl_word_t;

  function automatic ctrl_word_t microcode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{src: SRC_ADDR, hi: 1'b0, crc_en: 1'b1, last: 1'b0};
    unique case (step)
      5'd0:  w.src = SRC_ADDR;
      5'd1:  w.src = SRC_FUNC;
      5'd2:  w.src = SRC_LEN;
      5'd3:  w.src = SRC_T2;
      5'd4:  w.src = SRC_T3;
      5'd5:  w.src = SRC_T0;
      5'd6:  w.src = SRC_T1;
      5'd7:  w.src = SRC_TEMP_LO;
      5'd8:  w.src = SRC_TEMP_HI;
      5'd9:  w.src = SRC_DETS_HI;
      5'd10: w.src = SRC_DETS_LO;
      5'd11, 5'd15, 5'd19: w.src = SRC_DIST_HI;
      5'd12, 5'd16, 5'd20: w.src = SRC_DIST_LO;
      5'd13, 5'd17, 5'd21: w.src = SRC_AMPL_HI;
      5'd14, 5'd18, 5'd22: w.src = SRC_AMPL_LO;
      5'd23: w = '{src: SRC_CRC_LO, hi: 1'b0, crc_en: 1'b0, last: 1'b0};
      5'd24: w = '{src: SRC_CRC_LO, hi: 1'b1, crc_en: 1'b0, last: 1'b1};
      default: w = '{src: SRC_ADDR, hi: 1'b0, crc_en: 1'b0, last: 1'b1};
    endcase
    return w;
  endfunction

  // CRC-16/MODBUS, one byte: eight shift steps on the reflected register.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/rangefinder_response_framer_top.sv =====
// ----------------------------------------------------------------------------
// rangefinder_response_framer_top: Modbus RTU read-input-registers framer
// Turns one altitude/timestamp beat into a 25-byte response with CRC-16.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | direction | beat
//  --------+--------------------------------+-----------+-------------------------
//  in      | in_valid/in_ready/in_data      | sink      | altitude_cm, time_ms
//  out     | out_valid/out_ready/out_data   | source    | out_byte, frame_last
//  cfg     | cfg_valid/cfg_ready/cfg_index, | sink      | register write
//          | cfg_data                       |           |
//
//  Each input beat yields 25 output beats, at most one per cycle; the step
//  counter of the microcode sequencer sets the pace, and the next input beat
//  can be taken the cycle after the last byte is loaded, so a new item is
//  not accepted while a frame is in progress.
//  Reset (rst_n low, synchronous) returns the sequencer to idle, empties the
//  output register and loads the register defaults.
//  A stall on out_ready holds the output register and freezes the step
//  counter; nothing is dropped.
//
module rangefinder_response_framer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import rrf_pkg::*;

  // Configuration registers
  logic [7:0]  addr_r;
  logic [15:0] temp_r, dets_r, ampl_r;

  // Sequencer state
  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [15:0]       crc_r;

  // Captured item: timestamp and the scaled distance in millimetres
  logic [31:0] time_r;
  logic [15:0] dist_r;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic       in_fire, out_fire, load;
  ctrl_word_t cw;
  logic [7:0] byte_sel;
  logic [15:0] dist_nxt;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  // Advance one step whenever the output register is free or draining.
  assign load      = busy_r && (!out_valid_r || out_ready);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // altitude * 10 = (a << 3) + (a << 1), wrapped to 16 bits
  assign dist_nxt = {in_data.altitude_cm[12:0], 3'b000}
                  + {in_data.altitude_cm[14:0], 1'b0};

  // Fetch the control word for this step.
  assign cw = microcode(step_r);

  // Byte mux driven by the control word.
  always_comb begin
    unique case (cw.src)
      SRC_ADDR:    byte_sel = addr_r;
      SRC_FUNC:    byte_sel = FUNC_CODE;
      SRC_LEN:     byte_sel = LEN_BYTE;
      SRC_T2:      byte_sel = time_r[23:16];
      SRC_T3:      byte_sel = time_r[31:24];
      SRC_T0:      byte_sel = time_r[7:0];
      SRC_T1:      byte_sel = time_r[15:8];
      SRC_TEMP_LO: byte_sel = temp_r[7:0];
      SRC_TEMP_HI: byte_sel = temp_r[15:8];
      SRC_DETS_HI: byte_sel = dets_r[15:8];
      SRC_DETS_LO: byte_sel = dets_r[7:0];
      SRC_DIST_HI: byte_sel = dist_r[15:8];
      SRC_DIST_LO: byte_sel = dist_r[7:0];
      SRC_AMPL_HI: byte_sel = ampl_r[15:8];
      SRC_AMPL_LO: byte_sel = ampl_r[7:0];
      SRC_CRC_LO:  byte_sel = cw.hi ? crc_r[15:8] : crc_r[7:0];
      default:     byte_sel = 8'h00;
    endcase
  end

  // Register file: out-of-range indexes drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= RST_ADDR;
      temp_r <= RST_TEMP;
      dets_r <= RST_DETS;
      ampl_r <= RST_AMPL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADDR: addr_r <= cfg_data[7:0];
        REG_TEMP: temp_r <= cfg_data;
        REG_DETS: dets_r <= cfg_data;
        REG_AMPL: ampl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: start at step 0 on accept, jump back to idle on the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      crc_r  <= CRC_INIT;
    end else if (in_fire) begin
      busy_r <= 1'b1;
      step_r <= '0;
      crc_r  <= CRC_INIT;
    end else if (load) begin
      if (cw.crc_en) begin
        crc_r <= crc_byte(crc_r, byte_sel);
      end
      if (cw.last) begin
        busy_r <= 1'b0;
        step_r <= '0;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // Capture the item payload; hold it for the whole frame.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      time_r <= in_data.time_ms;
      dist_r <= dist_nxt;
    end
  end

  // Output register: load a byte per step, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_byte   <= byte_sel;
      out_data_r.frame_last <= cw.last;
    end
  end

  // A new frame starts at step 0 with a fresh CRC.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy_r && step_r == '0 && crc_r == CRC_INIT)
    else $error("frame did not start at step 0 with CRC init");

  // The step counter never runs past the program.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < STEP_W'(FRAME_BYTES))
    else $error("step counter out of range");

  // The last-step load ends the frame and frees the input side.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    load && cw.last |=> !busy_r && out_valid_r && out_data_r.frame_last)
    else $error("last step did not end the frame");

  // The first byte of every frame carries the device address.
  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    load && step_r == '0 |=> out_data_r.out_byte == $past(addr_r)
                             && !out_data_r.frame_last)
    else $error("first byte is not the device address");

endmodule
